FILE: src/rrts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_pkg
// types and constants shared by the round-robin task scheduler modules
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int ID_W    = 4;
    localparam int SLICE_W = 8;
    localparam logic [SLICE_W-1:0] INIT_SLICE = 8'd2;

    typedef enum logic [1:0] {
        FUNC_ALLOC  = 2'd0,
        FUNC_RUN    = 2'd1,
        FUNC_SLEEP  = 2'd2,
        FUNC_SWITCH = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        SLOT_FREE  = 2'd0,
        SLOT_SLEEP = 2'd1,
        SLOT_RUN   = 2'd2
    } slot_st_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_RESP = 2'd2
    } state_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [ID_W-1:0]    task_id;
        logic [SLICE_W-1:0] priority_req;
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]    task_id_out;
        logic               jump;
        logic               set_timer;
        logic [SLICE_W-1:0] slice;
        logic               status;
    } rsp_t;

    // command broadcast to every cell
    typedef struct packed {
        logic               exec;
        func_t              op;
        logic               id_ok;
        logic               target_run;
        logic [SLICE_W-1:0] prio;
    } cell_ctl_t;

    // per-cell flags gathered by the top level
    typedef struct packed {
        logic claim;
        logic target_run;
        logic match_lt;
        logic cur_match;
    } cell_flag_t;

endpackage
`default_nettype wire

FILE: src/rrts_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_cell
// one task slot plus one run list entry; shifts its entry from the upper
// neighbor when a task put to sleep is removed from the run list below or at it
// ----------------------------------------------------------------------------
module rrts_cell
    import rrts_pkg::*;
#(
    parameter int NUM_TASKS = 16,
    parameter int K         = 0
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cell_ctl_t                     ctl,
    input  wire logic [$clog2(NUM_TASKS)-1:0]  id,
    input  wire logic [$clog2(NUM_TASKS+1)-1:0] count,
    input  wire logic [$clog2(NUM_TASKS)-1:0]  cur,
    input  wire logic [$clog2(NUM_TASKS)-1:0]  upper_entry,
    input  wire logic                          free_in,
    output logic                               free_out,
    input  wire logic                          match_in,
    output logic                               match_out,
    output logic [$clog2(NUM_TASKS)-1:0]       entry,
    output logic [SLICE_W-1:0]                 slice,
    output cell_flag_t                         flag
);

    localparam int IW = $clog2(NUM_TASKS);
    localparam int CW = $clog2(NUM_TASKS + 1);
    localparam logic [IW-1:0] K_ID   = IW'(K);
    localparam logic [CW-1:0] K_CNT  = CW'(K);
    localparam logic [CW-1:0] K1_CNT = CW'(K + 1);
    localparam logic [CW-1:0] N_CNT  = CW'(NUM_TASKS);

    slot_st_t           status_reg, status_next;
    logic [SLICE_W-1:0] slice_reg, slice_next;
    logic [IW-1:0]      entry_reg, entry_next;

    logic is_me;
    logic is_free;
    logic match;
    logic append;
    logic shift;

    always_comb
    begin
        is_me    = ctl.id_ok && (id == K_ID);
        is_free  = (status_reg == SLOT_FREE);
        match    = (K_CNT < count) && (entry_reg == id);
        free_out  = free_in || is_free;
        match_out = match_in || match;

        append = ctl.exec && (ctl.op == FUNC_RUN) && ctl.id_ok && !ctl.target_run
                 && (count < N_CNT);
        shift  = ctl.exec && (ctl.op == FUNC_SLEEP) && ctl.id_ok && ctl.target_run
                 && (match_in || match) && (K1_CNT < count);

        flag.claim      = (ctl.op == FUNC_ALLOC) && is_free && !free_in;
        flag.target_run = is_me && (status_reg == SLOT_RUN);
        flag.match_lt   = match && (K_ID < cur);
        flag.cur_match  = match && (K_ID == cur);

        status_next = status_reg;
        slice_next  = slice_reg;
        entry_next  = entry_reg;
        if (ctl.exec)
        begin
            case (ctl.op)
                FUNC_ALLOC:
                begin
                    if (flag.claim)
                        status_next = SLOT_SLEEP;
                end
                FUNC_RUN:
                begin
                    if (is_me && (ctl.prio != '0))
                        slice_next = ctl.prio;
                    if (append && is_me)
                        status_next = SLOT_RUN;
                    if (append && (count == K_CNT))
                        entry_next = id;
                end
                FUNC_SLEEP:
                begin
                    if (is_me && ctl.target_run)
                        status_next = SLOT_SLEEP;
                    if (shift)
                        entry_next = upper_entry;
                end
                default:
                begin
                    status_next = status_reg;
                end
            endcase
        end
        entry = entry_reg;
        slice = slice_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= (K == 0) ? SLOT_RUN : SLOT_FREE;
            slice_reg  <= (K == 0) ? INIT_SLICE : '0;
            entry_reg  <= '0;
        end
        else
        begin
            status_reg <= status_next;
            slice_reg  <= slice_next;
            entry_reg  <= entry_next;
        end
    end

endmodule
`default_nettype wire

FILE: src/round_robin_task_scheduler_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_top
// round-robin task scheduler built as a row of slot cells with a small
// command sequencer
// ----------------------------------------------------------------------------
// busy covers execute and respond; a new command is accepted only in idle
// the cell row updates in the execute cycle, the result is read out in the respond cycle
// reset: slot 0 running with slice 2, all other slots free, current index zero
// the receiver cannot stall: done is high for exactly one cycle, result holds until the next one
module round_robin_task_scheduler_top
    import rrts_pkg::*;
#(
    parameter int NUM_TASKS = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire cmd_t cmd,
    output logic      done,
    output rsp_t      result
);

    localparam int IW = $clog2(NUM_TASKS);
    localparam int CW = $clog2(NUM_TASKS + 1);

    state_t        state_reg, state_next;
    cmd_t          cmd_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] cur_reg, cur_next;

    logic          rsp_read_reg, rsp_read_next;
    logic          rsp_jump_reg, rsp_jump_next;
    logic          rsp_timer_reg, rsp_timer_next;
    logic          rsp_status_reg, rsp_status_next;
    logic [IW-1:0] rsp_id_reg, rsp_id_next;

    rsp_t          result_reg, result_next;
    logic          done_reg, done_next;

    cell_ctl_t     ctl;
    logic [IW-1:0] id;
    logic          id_ok;

    logic [IW-1:0]      entry_arr [NUM_TASKS];
    logic [SLICE_W-1:0] slice_arr [NUM_TASKS];
    cell_flag_t         flag_arr  [NUM_TASKS];
    logic [NUM_TASKS:0] free_chain;
    logic [NUM_TASKS:0] match_chain;

    logic          target_run;
    logic          match_lt_any;
    logic          cur_match_any;
    logic [IW-1:0] claim_idx;

    logic [IW+ID_W-1:0] id_wide;
    logic [IW+ID_W-1:0] out_wide;
    logic [IW-1:0]      rd_id;

    always_comb
    begin
        id_wide = {{IW{1'b0}}, cmd_reg.task_id};
        id      = id_wide[IW-1:0];
        id_ok   = (32'(cmd_reg.task_id) < NUM_TASKS);
    end

    always_comb
    begin
        target_run    = 1'b0;
        match_lt_any  = 1'b0;
        cur_match_any = 1'b0;
        claim_idx     = '0;
        for (int k = 0; k < NUM_TASKS; k++)
        begin
            target_run    = target_run | flag_arr[k].target_run;
            match_lt_any  = match_lt_any | flag_arr[k].match_lt;
            cur_match_any = cur_match_any | flag_arr[k].cur_match;
            if (flag_arr[k].claim)
                claim_idx = claim_idx | IW'(k);
        end
        ctl.exec       = (state_reg == S_EXEC);
        ctl.op         = func_t'(cmd_reg.func);
        ctl.id_ok      = id_ok;
        ctl.target_run = target_run;
        ctl.prio       = cmd_reg.priority_req;
    end

    assign free_chain[0]          = 1'b0;
    assign match_chain[0]         = 1'b0;

    for (genvar k = 0; k < NUM_TASKS; k++)
    begin : g_cell
        logic [IW-1:0] upper;
        if (k == NUM_TASKS - 1)
        begin : g_last
            assign upper = '0;
        end
        else
        begin : g_mid
            assign upper = entry_arr[k+1];
        end

        rrts_cell #(
            .NUM_TASKS (NUM_TASKS),
            .K         (k)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .id          (id),
            .count       (count_reg),
            .cur         (cur_reg),
            .upper_entry (upper),
            .free_in     (free_chain[k]),
            .free_out    (free_chain[k+1]),
            .match_in    (match_chain[k]),
            .match_out   (match_chain[k+1]),
            .entry       (entry_arr[k]),
            .slice       (slice_arr[k]),
            .flag        (flag_arr[k])
        );
    end

    // sequencer and bookkeeping of count and current index
    always_comb
    begin
        logic [CW-1:0] cnt_dec;
        logic [IW-1:0] cur_adj;
        logic [CW-1:0] cur_inc;

        state_next      = state_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        rsp_read_next   = rsp_read_reg;
        rsp_jump_next   = rsp_jump_reg;
        rsp_timer_next  = rsp_timer_reg;
        rsp_status_next = rsp_status_reg;
        rsp_id_next     = rsp_id_reg;
        result_next     = result_reg;
        done_next       = 1'b0;

        cnt_dec = count_reg - 1'b1;
        cur_adj = match_lt_any ? (cur_reg - 1'b1) : cur_reg;
        cur_inc = CW'(cur_reg) + 1'b1;

        rd_id    = entry_arr[cur_reg];
        out_wide = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next      = S_RESP;
                rsp_read_next   = 1'b0;
                rsp_jump_next   = 1'b0;
                rsp_timer_next  = 1'b0;
                rsp_status_next = 1'b0;
                rsp_id_next     = '0;
                case (ctl.op)
                    FUNC_ALLOC:
                    begin
                        if (free_chain[NUM_TASKS])
                            rsp_id_next = claim_idx;
                        else
                            rsp_status_next = 1'b1;
                    end
                    FUNC_RUN:
                    begin
                        if (id_ok && !target_run && (count_reg < CW'(NUM_TASKS)))
                            count_next = count_reg + 1'b1;
                    end
                    FUNC_SLEEP:
                    begin
                        if (id_ok && target_run)
                        begin
                            count_next = cnt_dec;
                            if (CW'(cur_adj) >= cnt_dec)
                                cur_next = '0;
                            else
                                cur_next = cur_adj;
                            if (cur_match_any && (cnt_dec != '0))
                            begin
                                rsp_read_next = 1'b1;
                                rsp_jump_next = 1'b1;
                            end
                        end
                    end
                    FUNC_SWITCH:
                    begin
                        if (count_reg != '0)
                        begin
                            if (cur_inc >= count_reg)
                                cur_next = '0;
                            else
                                cur_next = cur_inc[IW-1:0];
                            rsp_read_next  = 1'b1;
                            rsp_timer_next = 1'b1;
                            rsp_jump_next  = (count_reg >= CW'(2));
                        end
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_RESP:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                // current index already moved in the execute cycle
                if (rsp_read_reg)
                begin
                    out_wide          = {{ID_W{1'b0}}, rd_id};
                    result_next.slice = slice_arr[rd_id];
                end
                else
                begin
                    out_wide          = {{ID_W{1'b0}}, rsp_id_reg};
                    result_next.slice = '0;
                end
                result_next.task_id_out = out_wide[ID_W-1:0];
                result_next.jump        = rsp_jump_reg;
                result_next.set_timer   = rsp_timer_reg;
                result_next.status      = rsp_status_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= CW'(1);
            cur_reg        <= '0;
            done_reg       <= 1'b0;
            rsp_read_reg   <= 1'b0;
            rsp_jump_reg   <= 1'b0;
            rsp_timer_reg  <= 1'b0;
            rsp_status_reg <= 1'b0;
            rsp_id_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            cur_reg        <= cur_next;
            done_reg       <= done_next;
            rsp_read_reg   <= rsp_read_next;
            rsp_jump_reg   <= rsp_jump_next;
            rsp_timer_reg  <= rsp_timer_next;
            rsp_status_reg <= rsp_status_next;
            rsp_id_reg     <= rsp_id_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if ((state_reg == S_IDLE) && start)
            cmd_reg <= cmd;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_EXEC))
        else $error("start transfer did not enter execute");

    a_done_after_resp: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg == S_RESP) && !busy))
        else $error("result strobe outside respond step");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(NUM_TASKS))
        else $error("run count beyond slot count");

    a_cur_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (CW'(cur_reg) < count_reg) || (cur_reg == '0))
        else $error("current index outside run list");

    a_timer_only_switch: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.set_timer) |-> (result.status == 1'b0))
        else $error("timer reload on a failed alloc");

endmodule
`default_nettype wire
